[hdl/detm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped Euler transform matrix package
// Shared types, constants and arithmetic helpers of the transform matrix core.
// ----------------------------------------------------------------------------
package detm_pkg;

   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_ROTATE = 1'b1;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [1:0] REG_DAMPING = 2'd0;
   localparam logic [1:0] REG_SCALE_X = 2'd1;
   localparam logic [1:0] REG_SCALE_Y = 2'd2;
   localparam logic [1:0] REG_SCALE_Z = 2'd3;

   localparam int CORDIC_ITERS = 16;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [20:0] PI_Q16      = 21'sd205887;
   localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;
   localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_ROTATE,
      KIND_NOP
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_DAMP_MUL,
      ST_DAMP_ADD,
      ST_SC_START,
      ST_SC_WAIT,
      ST_ROW_LOAD,
      ST_ROT_MAC,
      ST_ROW_STORE,
      ST_RESULT
   } eng_state_type;

   typedef struct packed {
      logic               command;
      logic [1:0]         axis;
      logic signed [19:0] angle_delta;
      logic signed [19:0] target_angle_x;
      logic signed [19:0] target_angle_y;
      logic signed [19:0] target_angle_z;
      logic signed [19:0] target_orbit_x;
      logic signed [19:0] target_orbit_y;
      logic signed [19:0] target_orbit_z;
      logic signed [31:0] target_pos_x;
      logic signed [31:0] target_pos_y;
      logic signed [31:0] target_pos_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] row0_x;
      logic signed [31:0] row0_y;
      logic signed [31:0] row0_z;
      logic signed [31:0] row1_x;
      logic signed [31:0] row1_y;
      logic signed [31:0] row1_z;
      logic signed [31:0] row2_x;
      logic signed [31:0] row2_y;
      logic signed [31:0] row2_z;
      logic signed [31:0] row3_x;
      logic signed [31:0] row3_y;
      logic signed [31:0] row3_z;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [23:0] wdata;
   } csr_type;

   typedef struct packed {
      logic [16:0]        damping;
      logic signed [23:0] scale_x;
      logic signed [23:0] scale_y;
      logic signed [23:0] scale_z;
   } cfg_type;

   typedef struct packed {
      kind_type kind;
      req_type  req;
   } item_type;

   function automatic logic [15:0] atan_entry(input logic [3:0] i);
      logic [15:0] r;
      unique case (i)
         4'd0:    r = 16'd51472;
         4'd1:    r = 16'd30386;
         4'd2:    r = 16'd16055;
         4'd3:    r = 16'd8150;
         4'd4:    r = 16'd4091;
         4'd5:    r = 16'd2047;
         4'd6:    r = 16'd1024;
         4'd7:    r = 16'd512;
         4'd8:    r = 16'd256;
         4'd9:    r = 16'd128;
         4'd10:   r = 16'd64;
         4'd11:   r = 16'd32;
         4'd12:   r = 16'd16;
         4'd13:   r = 16'd8;
         4'd14:   r = 16'd4;
         default: r = 16'd2;
      endcase
      return r;
   endfunction

   // steps 0..2 spin x, y, z; steps 3..5 orbit z, x, y
   function automatic logic [1:0] step_axis(input logic [2:0] step);
      logic [1:0] r;
      unique case (step)
         3'd0:    r = AXIS_X;
         3'd1:    r = AXIS_Y;
         3'd2:    r = AXIS_Z;
         3'd3:    r = AXIS_Z;
         3'd4:    r = AXIS_X;
         3'd5:    r = AXIS_Y;
         default: r = AXIS_X;
      endcase
      return r;
   endfunction

   // round a Q2.30 weighted sum back to Q16.16 and saturate
   function automatic logic signed [31:0] round_q30(input logic signed [65:0] s);
      logic signed [65:0] t;
      logic signed [31:0] r;
      t = (s + 66'sd536870912) >>> 30;
      if (t > 66'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (t < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = t[31:0];
      end
      return r;
   endfunction

endpackage

[hdl/detm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped Euler transform matrix channels
// Valid/ready channel interfaces for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface detm_req_if;
   logic              valid;
   logic              ready;
   detm_pkg::req_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface detm_rsp_if;
   logic              valid;
   logic              ready;
   detm_pkg::rsp_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface detm_csr_if;
   logic              valid;
   logic              ready;
   detm_pkg::csr_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

[hdl/detm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped Euler transform matrix front queue
// Accepts request transactions, classifies them and buffers two entries.
// ----------------------------------------------------------------------------
module detm_queue (
   input  logic                clock,
   input  logic                reset,
   detm_req_if.sink            req_bus,
   output logic                q_valid,
   output detm_pkg::item_type  q_item,
   input  logic                q_pop
);

   detm_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   detm_pkg::item_type new_item;

   assign req_bus.ready = (count_ff != 2'd2);
   assign push = req_bus.valid && req_bus.ready;
   assign q_valid = (count_ff != 2'd0);
   assign q_item = entry_ff[rd_ptr_ff];

   // classify: unused axis turns a rotate into a no-op
   always_comb begin
      new_item.req = req_bus.payload;
      if (req_bus.payload.command == detm_pkg::CMD_TICK) begin
         new_item.kind = detm_pkg::KIND_TICK;
      end else if (req_bus.payload.axis == 2'd3) begin
         new_item.kind = detm_pkg::KIND_NOP;
      end else begin
         new_item.kind = detm_pkg::KIND_ROTATE;
      end
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[hdl/detm_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped Euler transform matrix CORDIC unit
// Sine and cosine of a Q4.16 angle in Q2.30, one iteration per cycle.
// ----------------------------------------------------------------------------
module detm_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [19:0] angle,
   output logic               done,
   output logic signed [31:0] sin_q30,
   output logic signed [31:0] cos_q30
);

   logic               active_ff, active_in;
   logic               done_ff, done_in;
   logic [3:0]         iter_ff, iter_in;
   logic               flip_ff, flip_in;
   logic signed [33:0] x_ff, x_in;
   logic signed [33:0] y_ff, y_in;
   logic signed [19:0] z_ff, z_in;
   logic signed [20:0] wrapped;
   logic signed [20:0] folded;
   logic signed [33:0] dx, dy;
   logic signed [19:0] atan_val;
   logic signed [33:0] x_neg, y_neg;

   always_comb begin
      // bring into [-pi, pi], then fold into [-pi/2, pi/2]
      wrapped = 21'(angle);
      if (wrapped > detm_pkg::PI_Q16) begin
         wrapped = wrapped - detm_pkg::TWO_PI_Q16;
      end else if (wrapped < -detm_pkg::PI_Q16) begin
         wrapped = wrapped + detm_pkg::TWO_PI_Q16;
      end
      folded = wrapped;
      flip_in = flip_ff;
      if (start) begin
         flip_in = 1'b0;
      end
      if (wrapped > detm_pkg::HALF_PI_Q16) begin
         folded = wrapped - detm_pkg::PI_Q16;
         if (start) flip_in = 1'b1;
      end else if (wrapped < -detm_pkg::HALF_PI_Q16) begin
         folded = wrapped + detm_pkg::PI_Q16;
         if (start) flip_in = 1'b1;
      end
   end

   always_comb begin
      dx = y_ff >>> iter_ff;
      dy = x_ff >>> iter_ff;
      atan_val = $signed({4'd0, detm_pkg::atan_entry(iter_ff)});
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      iter_in = iter_ff;
      active_in = active_ff;
      done_in = 1'b0;
      if (start) begin
         x_in = detm_pkg::CORDIC_GAIN;
         y_in = 34'sd0;
         z_in = folded[19:0];
         iter_in = 4'd0;
         active_in = 1'b1;
      end else if (active_ff) begin
         if (z_ff >= 20'sd0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_val;
         end
         iter_in = iter_ff + 4'd1;
         if (iter_ff == 4'(detm_pkg::CORDIC_ITERS - 1)) begin
            active_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      flip_ff <= flip_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x_neg = -x_ff;
   assign y_neg = -y_ff;
   assign done = done_ff;
   assign cos_q30 = flip_ff ? x_neg[31:0] : x_ff[31:0];
   assign sin_q30 = flip_ff ? y_neg[31:0] : y_ff[31:0];

endmodule

[hdl/detm_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped Euler transform matrix back end
// Damps the state, forms six sine/cosine pairs and rotates the matrix rows.
// ----------------------------------------------------------------------------
module detm_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  detm_pkg::item_type q_item,
   output logic               q_pop,
   input  detm_pkg::cfg_type  cfg,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output detm_pkg::rsp_type  rsp_payload
);

   localparam logic [1:0] AXIS_LAST = detm_pkg::AXIS_Z;

   detm_pkg::eng_state_type state_ff, state_in;
   detm_pkg::item_type item_ff;

   logic signed [19:0] spin_ff [3];
   logic signed [19:0] orbit_ff [3];
   logic signed [31:0] pos_ff [3];

   logic [1:0]         grp_ff;
   logic [1:0]         dax_ff;
   logic signed [51:0] dprod_ff;
   logic [2:0]         ci_ff;
   logic signed [31:0] sin_ff [6];
   logic signed [31:0] cos_ff [6];
   logic [1:0]         row_ff;
   logic [2:0]         step_ff;
   logic [2:0]         ph_ff;
   logic signed [31:0] v0_ff, v1_ff, v2_ff;
   logic signed [64:0] p_ff;
   logic signed [64:0] acc_ff;
   logic signed [31:0] hold_ff;
   logic signed [31:0] res_ff [4][3];
   logic               rsp_valid_ff;
   detm_pkg::rsp_type  rsp_ff;

   logic               cordic_start;
   logic               cordic_done;
   logic signed [19:0] cordic_angle;
   logic signed [31:0] cordic_sin, cordic_cos;
   logic [1:0]         orbit_idx;
   logic               damp_last;
   logic               slot_free;

   logic signed [32:0] cur_val, tgt_val;
   logic signed [33:0] diff;
   logic signed [35:0] delta;
   logic signed [36:0] sum_val, sat_val;
   logic signed [20:0] rot_sum;
   logic signed [19:0] rot_val;

   logic [1:0]         rax;
   logic [2:0]         sc_idx;
   logic signed [32:0] k_coef, c_coef;
   logic signed [31:0] va, vb, mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] mac_sum;
   logic signed [31:0] mac_rnd;

   detm_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (cordic_angle),
      .done    (cordic_done),
      .sin_q30 (cordic_sin),
      .cos_q30 (cordic_cos)
   );

   assign damp_last = (grp_ff == 2'd2) && (dax_ff == AXIS_LAST);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign orbit_idx = 2'(ci_ff - 3'd3);
   assign cordic_angle = (ci_ff < 3'd3) ? spin_ff[ci_ff[1:0]] : orbit_ff[orbit_idx];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         detm_pkg::ST_IDLE: begin
            if (q_valid) begin
               unique case (q_item.kind)
                  detm_pkg::KIND_TICK:   state_in = detm_pkg::ST_DAMP_MUL;
                  detm_pkg::KIND_ROTATE: state_in = detm_pkg::ST_ROTATE;
                  default:               state_in = detm_pkg::ST_IDLE;
               endcase
            end
         end
         detm_pkg::ST_ROTATE:   state_in = detm_pkg::ST_IDLE;
         detm_pkg::ST_DAMP_MUL: state_in = detm_pkg::ST_DAMP_ADD;
         detm_pkg::ST_DAMP_ADD: begin
            state_in = damp_last ? detm_pkg::ST_SC_START : detm_pkg::ST_DAMP_MUL;
         end
         detm_pkg::ST_SC_START: state_in = detm_pkg::ST_SC_WAIT;
         detm_pkg::ST_SC_WAIT: begin
            if (cordic_done) begin
               state_in = (ci_ff == 3'd5) ? detm_pkg::ST_ROW_LOAD : detm_pkg::ST_SC_START;
            end
         end
         detm_pkg::ST_ROW_LOAD: state_in = detm_pkg::ST_ROT_MAC;
         detm_pkg::ST_ROT_MAC: begin
            if (ph_ff == 3'd5 && step_ff == 3'd5) begin
               state_in = detm_pkg::ST_ROW_STORE;
            end
         end
         detm_pkg::ST_ROW_STORE: begin
            state_in = (row_ff == 2'd3) ? detm_pkg::ST_RESULT : detm_pkg::ST_ROW_LOAD;
         end
         detm_pkg::ST_RESULT: begin
            if (slot_free) state_in = detm_pkg::ST_IDLE;
         end
         default: state_in = detm_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop = 1'b0;
      cordic_start = 1'b0;
      unique case (state_ff)
         detm_pkg::ST_IDLE:     q_pop = q_valid;
         detm_pkg::ST_SC_START: cordic_start = 1'b1;
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // damping datapath
   always_comb begin
      unique case (grp_ff)
         2'd0:    cur_val = 33'(spin_ff[dax_ff]);
         2'd1:    cur_val = 33'(orbit_ff[dax_ff]);
         default: cur_val = 33'(pos_ff[dax_ff]);
      endcase
      unique case ({grp_ff, dax_ff})
         4'b0000: tgt_val = 33'(item_ff.req.target_angle_x);
         4'b0001: tgt_val = 33'(item_ff.req.target_angle_y);
         4'b0010: tgt_val = 33'(item_ff.req.target_angle_z);
         4'b0100: tgt_val = 33'(item_ff.req.target_orbit_x);
         4'b0101: tgt_val = 33'(item_ff.req.target_orbit_y);
         4'b0110: tgt_val = 33'(item_ff.req.target_orbit_z);
         4'b1000: tgt_val = 33'(item_ff.req.target_pos_x);
         4'b1001: tgt_val = 33'(item_ff.req.target_pos_y);
         default: tgt_val = 33'(item_ff.req.target_pos_z);
      endcase
      diff = 34'(tgt_val) - 34'(cur_val);
      delta = 36'((dprod_ff + 52'sd32768) >>> 16);
      sum_val = 37'(cur_val) + 37'(delta);
      sat_val = sum_val;
      if (grp_ff != 2'd2) begin
         if (sum_val > 37'sd524287) sat_val = 37'sd524287;
         else if (sum_val < -37'sd524288) sat_val = -37'sd524288;
      end else begin
         if (sum_val > 37'sd2147483647) sat_val = 37'sd2147483647;
         else if (sum_val < -37'sd2147483648) sat_val = -37'sd2147483648;
      end
      rot_sum = 21'(spin_ff[item_ff.req.axis]) + 21'(item_ff.req.angle_delta);
      if (rot_sum > 21'sd524287) rot_val = 20'sd524287;
      else if (rot_sum < -21'sd524288) rot_val = -20'sd524288;
      else rot_val = rot_sum[19:0];
   end

   // rotation multiply-accumulate datapath
   always_comb begin
      rax = detm_pkg::step_axis(step_ff);
      sc_idx = (step_ff < 3'd3) ? step_ff : 3'(3'd3 + 3'(rax));
      c_coef = 33'(cos_ff[sc_idx]);
      k_coef = (rax == detm_pkg::AXIS_Y) ? 33'(sin_ff[sc_idx]) : -33'(sin_ff[sc_idx]);
      va = (rax == detm_pkg::AXIS_X) ? v1_ff : v0_ff;
      vb = (rax == detm_pkg::AXIS_Z) ? v1_ff : v2_ff;
      unique case (ph_ff)
         3'd0:    begin mul_a = va; mul_b = c_coef;  end
         3'd1:    begin mul_a = vb; mul_b = k_coef;  end
         3'd3:    begin mul_a = va; mul_b = -k_coef; end
         default: begin mul_a = vb; mul_b = c_coef;  end
      endcase
      mac_sum = 66'(acc_ff) + 66'(p_ff);
      mac_rnd = detm_pkg::round_q30(mac_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= detm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            spin_ff[i] <= 20'sd0;
            orbit_ff[i] <= 20'sd0;
            pos_ff[i] <= 32'sd0;
         end
      end else begin
         state_ff <= state_in;
         // load a new matrix, or drop valid once the waiting one is taken
         if (state_ff == detm_pkg::ST_RESULT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // commit state updates
         if (state_ff == detm_pkg::ST_ROTATE) begin
            spin_ff[item_ff.req.axis] <= rot_val;
         end
         if (state_ff == detm_pkg::ST_DAMP_ADD) begin
            unique case (grp_ff)
               2'd0:    spin_ff[dax_ff] <= sat_val[19:0];
               2'd1:    orbit_ff[dax_ff] <= sat_val[19:0];
               default: pos_ff[dax_ff] <= sat_val[31:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         detm_pkg::ST_IDLE: begin
            item_ff <= q_item;
            grp_ff <= 2'd0;
            dax_ff <= 2'd0;
            ci_ff <= 3'd0;
            row_ff <= 2'd0;
         end
         detm_pkg::ST_DAMP_MUL: begin
            dprod_ff <= diff * $signed({1'b0, cfg.damping});
         end
         detm_pkg::ST_DAMP_ADD: begin
            if (dax_ff == AXIS_LAST) begin
               dax_ff <= 2'd0;
               grp_ff <= grp_ff + 2'd1;
            end else begin
               dax_ff <= dax_ff + 2'd1;
            end
         end
         detm_pkg::ST_SC_WAIT: begin
            if (cordic_done) begin
               sin_ff[ci_ff] <= cordic_sin;
               cos_ff[ci_ff] <= cordic_cos;
               ci_ff <= ci_ff + 3'd1;
            end
         end
         detm_pkg::ST_ROW_LOAD: begin
            ph_ff <= 3'd0;
            step_ff <= (row_ff == 2'd3) ? 3'd3 : 3'd0;
            unique case (row_ff)
               2'd0: begin
                  v0_ff <= 32'(cfg.scale_x); v1_ff <= 32'sd0; v2_ff <= 32'sd0;
               end
               2'd1: begin
                  v0_ff <= 32'sd0; v1_ff <= 32'(cfg.scale_y); v2_ff <= 32'sd0;
               end
               2'd2: begin
                  v0_ff <= 32'sd0; v1_ff <= 32'sd0; v2_ff <= 32'(cfg.scale_z);
               end
               default: begin
                  v0_ff <= pos_ff[0]; v1_ff <= pos_ff[1]; v2_ff <= pos_ff[2];
               end
            endcase
         end
         detm_pkg::ST_ROT_MAC: begin
            p_ff <= mul_a * mul_b;
            if (ph_ff == 3'd1 || ph_ff == 3'd4) begin
               acc_ff <= p_ff;
            end
            if (ph_ff == 3'd2) begin
               hold_ff <= mac_rnd;
            end
            if (ph_ff == 3'd5) begin
               ph_ff <= 3'd0;
               step_ff <= step_ff + 3'd1;
               // first output lands in the lower axis, second in the upper
               unique case (rax)
                  detm_pkg::AXIS_X: begin v1_ff <= hold_ff; v2_ff <= mac_rnd; end
                  detm_pkg::AXIS_Y: begin v0_ff <= hold_ff; v2_ff <= mac_rnd; end
                  default:          begin v0_ff <= hold_ff; v1_ff <= mac_rnd; end
               endcase
            end else begin
               ph_ff <= ph_ff + 3'd1;
            end
         end
         detm_pkg::ST_ROW_STORE: begin
            res_ff[row_ff][0] <= v0_ff;
            res_ff[row_ff][1] <= v1_ff;
            res_ff[row_ff][2] <= v2_ff;
            row_ff <= row_ff + 2'd1;
         end
         detm_pkg::ST_RESULT: begin
            if (slot_free) begin
               rsp_ff.row0_x <= res_ff[0][0];
               rsp_ff.row0_y <= res_ff[0][1];
               rsp_ff.row0_z <= res_ff[0][2];
               rsp_ff.row1_x <= res_ff[1][0];
               rsp_ff.row1_y <= res_ff[1][1];
               rsp_ff.row1_z <= res_ff[1][2];
               rsp_ff.row2_x <= res_ff[2][0];
               rsp_ff.row2_y <= res_ff[2][1];
               rsp_ff.row2_z <= res_ff[2][2];
               rsp_ff.row3_x <= res_ff[3][0];
               rsp_ff.row3_y <= res_ff[3][1];
               rsp_ff.row3_z <= res_ff[3][2];
            end
         end
         default: begin
            ph_ff <= ph_ff;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[hdl/damped_euler_transform_matrix_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped Euler transform matrix core
// Damped spin/orbit/position state and a 4x3 world matrix per tick.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  req_bus   in         tick targets or a spin rotate delta
//  rsp_bus   out        4x3 world matrix, Q16.16 saturated
//  csr_bus   in         damping and row scale register writes
//
//  A tick damps the nine values (one multiplier, multiply then add),
//  forms six sine/cosine pairs through the single 16-step CORDIC and
//  runs 21 row rotations on one shared multiplier.
//  Reset clears the state, the registers and all handshake control.
//  A two-entry queue takes requests while the back end works, and the
//  response register lets the back end start the next item while a
//  finished matrix waits to be taken.
// ----------------------------------------------------------------------------
module damped_euler_transform_matrix_core (
   input  logic       clock,
   input  logic       reset,
   detm_req_if.sink   req_bus,
   detm_rsp_if.source rsp_bus,
   detm_csr_if.sink   csr_bus
);

   detm_pkg::cfg_type  cfg_ff;
   logic               q_valid;
   logic               q_pop;
   detm_pkg::item_type q_item;

   // register writes never stall
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.damping <= 17'd65536;
         cfg_ff.scale_x <= 24'sd65536;
         cfg_ff.scale_y <= 24'sd65536;
         cfg_ff.scale_z <= 24'sd65536;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.payload.index)
            detm_pkg::REG_DAMPING: cfg_ff.damping <= csr_bus.payload.wdata[16:0];
            detm_pkg::REG_SCALE_X: cfg_ff.scale_x <= csr_bus.payload.wdata;
            detm_pkg::REG_SCALE_Y: cfg_ff.scale_y <= csr_bus.payload.wdata;
            default:               cfg_ff.scale_z <= csr_bus.payload.wdata;
         endcase
      end
   end

   // front: accept and classify each transaction
   detm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   // back: damp, build sine/cosine pairs, rotate rows, hold the result
   detm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .cfg         (cfg_ff),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .rsp_payload (rsp_bus.payload)
   );

endmodule

[hdl/detm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped Euler transform matrix checker
// Port-level assertions on the core, attached by bind.
// ----------------------------------------------------------------------------
module detm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_command,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input detm_pkg::rsp_type rsp_payload
);

   logic [2:0] pending_ff, pending_in;
   logic       tick_acc, rsp_acc;

   assign tick_acc = req_valid && req_ready && (req_command == detm_pkg::CMD_TICK);
   assign rsp_acc = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + 3'(tick_acc) - 3'(rsp_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("response payload changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response without an outstanding tick");

endmodule

bind damped_euler_transform_matrix_core detm_checker u_detm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .req_command (req_bus.payload.command),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);
